// ----- hw/rtl/bounded_shift_array_top_assert.svh -----
// Assertion macros for the bounded shift array checker.
// Depends on nothing; included by the checker file.
`ifndef BOUNDED_SHIFT_ARRAY_TOP_ASSERT_SVH
`define BOUNDED_SHIFT_ARRAY_TOP_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bsa_pkg.sv -----
// Shared types and codes for the bounded shift array.
// No dependencies; imported by the top level and its checker.
package bsa_pkg;

   localparam int OPCODE_W    = 4;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 9;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 64;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK   = 4'd0,
      OP_POP_BACK    = 4'd1,
      OP_PUSH_FRONT  = 4'd2,
      OP_POP_FRONT   = 4'd3,
      OP_INSERT      = 4'd4,
      OP_ERASE       = 4'd5,
      OP_SEARCH      = 4'd6,
      OP_ERASE_FIRST = 4'd7,
      OP_ERASE_ALL   = 4'd8,
      OP_CLEAR       = 4'd9,
      OP_READ        = 4'd10,
      OP_WRITE       = 4'd11
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]       pad;
      logic [POS_W-1:0] position;
      value_type        value;
      logic [OPCODE_W-1:0] opcode;
   } req_fields_type;

   typedef struct packed {
      logic             is_full;
      logic             is_empty;
      logic [POS_W-1:0] fill_count;
      value_type        read_data;
      logic [POS_W-1:0] removed_count;
      logic [POS_W-1:0] found_index;
      logic             found;
      logic [STATUS_W-1:0] status;
   } rsp_fields_type;

endpackage

// ----- hw/rtl/bounded_shift_array_top.sv -----
// Bounded shift array: ordered store of signed words with a fill count.
// Depends on bsa_pkg.
//
// One command per transfer, one result per command. Push back, pop back, clear, read,
// write and every ignored command go straight from the request to the finish state.
// Push front and insert move each element from the position up one place, then write
// the new value there; pop front and erase move the elements above the position down,
// and search, erase first and erase all walk the store from the front. The request side
// is ready again in the cycle the result appears. The element memory does one read and
// one write per cycle, walked by a single read/write pointer pair. The request side is
// ready only between commands; a finished result waits in the output register while the
// next request is taken, and a result still held there stalls the next one. The store
// is not cleared after reset: entries at or above the fill count are never read.
module bounded_shift_array_top #(
   parameter int CAPACITY = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // opcode[3:0], value[35:4], position[44:36], zero pad
   input  logic [bsa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], found[2], found_index[11:3], removed_count[20:12],
   // read_data[52:21], fill_count[61:53], is_empty[62], is_full[63]
   output logic [bsa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bsa_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {S_IDLE, S_SHUP, S_SCAN, S_FINISH} state_type;
   typedef enum logic [1:0] {M_SEARCH, M_ERASE_FIRST, M_ERASE_ALL, M_SHIFT} mode_type;

   value_type element_store [CAPACITY];
   value_type rd_q_ff;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    wp_ff, wp_in;
   logic [AW-1:0]    wa_ff, wa_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic             pend_ff, pend_in;
   value_type        value_ff, value_in;
   status_type       status_ff, status_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] fidx_ff, fidx_in;
   logic [CW-1:0]    removed_ff, removed_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   rsp_fields_type   rsp_tdata_ff, rsp_tdata_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   value_type     wr_data;

   req_fields_type req;
   opcode_type     op;
   logic [XW-1:0]  pos_x, cnt_x;
   logic           full, empty;
   logic           hit, drop, stop, issue;
   logic [CW-1:0]  ptr_dec;

   assign req   = req_fields_type'(req_tdata);
   assign op    = opcode_type'(req.opcode);
   assign pos_x = XW'(req.position);
   assign cnt_x = XW'(count_ff);
   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);
   assign ptr_dec = ptr_ff - 1'b1;

   assign hit = pend_ff && (rd_q_ff == value_ff);

   always_comb begin
      unique case (mode_ff)
         M_SEARCH, M_ERASE_FIRST: drop = hit && !found_ff;
         M_ERASE_ALL:             drop = hit;
         M_SHIFT:                 drop = 1'b0;
      endcase
      stop  = (mode_ff == M_SEARCH) && (found_ff || drop);
      issue = (ptr_ff < count_ff) && !stop;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      wp_in         = wp_ff;
      wa_in         = wa_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      removed_in    = removed_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               value_in   = req.value;
               status_in  = ST_DONE;
               found_in   = 1'b0;
               fidx_in    = '0;
               removed_in = '0;
               rd_ok_in   = 1'b0;
               pend_in    = 1'b0;
               state_in   = S_FINISH;
               unique case (op)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) status_in = ST_EMPTY;
                     else count_in = count_ff - 1'b1;
                  end
                  OP_PUSH_FRONT, OP_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (op == OP_INSERT && pos_x > cnt_x) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        pos_in   = (op == OP_INSERT) ? AW'(req.position) : '0;
                        ptr_in   = count_ff;
                        state_in = S_SHUP;
                     end
                  end
                  OP_POP_FRONT, OP_ERASE: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (op == OP_ERASE && pos_x >= cnt_x) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        wp_in    = (op == OP_ERASE) ? CW'(req.position) : '0;
                        ptr_in   = ((op == OP_ERASE) ? CW'(req.position) : '0) + 1'b1;
                        mode_in  = M_SHIFT;
                        state_in = S_SCAN;
                     end
                  end
                  OP_SEARCH, OP_ERASE_FIRST, OP_ERASE_ALL: begin
                     ptr_in   = '0;
                     wp_in    = '0;
                     fidx_in  = (op == OP_ERASE_ALL) ? '0 : POS_W'(count_ff);
                     mode_in  = (op == OP_SEARCH) ? M_SEARCH :
                                (op == OP_ERASE_FIRST) ? M_ERASE_FIRST : M_ERASE_ALL;
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: count_in = '0;
                  OP_READ: begin
                     if (pos_x >= cnt_x) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req.position);
                        rd_ok_in = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     if (pos_x >= cnt_x) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req.position);
                        wr_data = req.value;
                     end
                  end
                  default: status_in = ST_BAD_INDEX;
               endcase
            end
         end

         S_SHUP: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = rd_q_ff;
            end
            if (ptr_ff > CW'(pos_ff)) begin
               rd_en   = 1'b1;
               rd_addr = ptr_dec[AW-1:0];
               wa_in   = ptr_ff[AW-1:0];
               ptr_in  = ptr_dec;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff;
                  wr_data  = value_ff;
                  count_in = count_ff + 1'b1;
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            pend_in = issue;
            if (issue) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (drop) begin
                  if (mode_ff == M_ERASE_ALL) begin
                     removed_in = removed_ff + 1'b1;
                  end else begin
                     found_in = 1'b1;
                     fidx_in  = POS_W'(wp_ff);
                  end
               end else begin
                  if (mode_ff != M_SEARCH) begin
                     wr_en   = 1'b1;
                     wr_addr = wp_ff[AW-1:0];
                     wr_data = rd_q_ff;
                  end
                  wp_in = wp_ff + 1'b1;
               end
            end else if (!issue) begin
               if (mode_ff != M_SEARCH) count_in = wp_ff;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in.status        = status_ff;
               rsp_tdata_in.found         = found_ff;
               rsp_tdata_in.found_index   = fidx_ff;
               rsp_tdata_in.removed_count = POS_W'(removed_ff);
               rsp_tdata_in.read_data     = rd_ok_ff ? rd_q_ff : '0;
               rsp_tdata_in.fill_count    = POS_W'(count_ff);
               rsp_tdata_in.is_empty      = empty;
               rsp_tdata_in.is_full       = full;
               rsp_tvalid_in              = 1'b1;
               state_in                   = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) element_store[wr_addr] <= wr_data;
      if (rd_en) rd_q_ff <= element_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= M_SEARCH;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      ptr_ff       <= ptr_in;
      wp_ff        <= wp_in;
      wa_ff        <= wa_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      fidx_ff      <= fidx_in;
      removed_ff   <= removed_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- hw/rtl/bsa_checker.sv -----
// Port-level checks for the bounded shift array, bound to the top level.
// Depends on bsa_pkg and bounded_shift_array_top_assert.svh.
`include "bounded_shift_array_top_assert.svh"

module bsa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bsa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bsa_pkg::*;

   rsp_fields_type rsp;
   logic           req_xfer;
   logic           ignored;

   assign rsp      = rsp_fields_type'(rsp_tdata);
   assign req_xfer = req_tvalid && req_tready;
   assign ignored  = rsp_tvalid && (rsp.status != ST_DONE);

   `BSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `BSA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_tready, "request taken while a command is in progress")
   `BSA_ASSERT_NOW(a_ignored_clean, clock, reset, ignored, !rsp.found && rsp.found_index == '0 && rsp.removed_count == '0 && rsp.read_data == '0, "ignored command carries data")
   `BSA_ASSERT_NOW(a_empty_full, clock, reset, rsp_tvalid, !(rsp.is_empty && rsp.is_full), "empty and full together")

endmodule

bind bounded_shift_array_top bsa_checker u_bsa_checker (.*);
